[src/fsst_pkg.sv]
// ----------------------------------------------------------------------------
// fsst_pkg
// Shared types and codes for the first seen source table.
// ----------------------------------------------------------------------------
package fsst_pkg;

    localparam int HASH_W = 256;
    localparam int WORD_W = 64;
    localparam int STAMP_W = 32;
    localparam int KIND_W = 2;

    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TX = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BLOCK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [HASH_W-1:0]  hash;
        logic [WORD_W-1:0]  addr_high;
        logic [WORD_W-1:0]  addr_low;
        logic               ipv4;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic               accepted;
        logic               inserted;
        logic               found;
        logic [WORD_W-1:0]  addr_high;
        logic [WORD_W-1:0]  addr_low;
        logic               ipv4;
        logic [STAMP_W-1:0] stamp;
    } t_result;

endpackage

[src/fsst_if.sv]
// ----------------------------------------------------------------------------
// fsst_if
// Item channels of the first seen source table: request and result.
// ----------------------------------------------------------------------------
interface fsst_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [63:0] hash_word0;
    logic [63:0] hash_word1;
    logic [63:0] hash_word2;
    logic [63:0] hash_word3;
    logic [63:0] peer_addr_high;
    logic [63:0] peer_addr_low;
    logic        peer_is_ipv4;
    logic [1:0]  msg_kind;
    logic [31:0] now_seconds;

    modport source (
        output valid, op, hash_word0, hash_word1, hash_word2, hash_word3,
               peer_addr_high, peer_addr_low, peer_is_ipv4, msg_kind, now_seconds,
        input  ready
    );
    modport sink (
        input  valid, op, hash_word0, hash_word1, hash_word2, hash_word3,
               peer_addr_high, peer_addr_low, peer_is_ipv4, msg_kind, now_seconds,
        output ready
    );
endinterface

interface fsst_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        inserted;
    logic        found;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic        src_is_ipv4;
    logic [31:0] first_seen_time;

    modport source (
        output valid, accepted, inserted, found, src_addr_high, src_addr_low,
               src_is_ipv4, first_seen_time,
        input  ready
    );
    modport sink (
        input  valid, accepted, inserted, found, src_addr_high, src_addr_low,
               src_is_ipv4, first_seen_time,
        output ready
    );
endinterface

[src/fsst_filter.sv]
// ----------------------------------------------------------------------------
// fsst_filter
// Message type and public address filter for register items.
// ----------------------------------------------------------------------------
module fsst_filter (
    input  logic        i_op,
    input  logic [1:0]  i_msg_kind,
    input  logic [63:0] i_peer_addr_high,
    input  logic [63:0] i_peer_addr_low,
    input  logic        i_peer_is_ipv4,
    output logic        o_pass
);
    logic [7:0] b0;
    logic [7:0] b1;
    logic       v4_private;
    logic       v6_private;
    logic       addr_public;

    assign b0 = i_peer_addr_low[31:24];
    assign b1 = i_peer_addr_low[23:16];

    always_comb begin
        v4_private = (b0 == 8'd10)
                  || (b0 == 8'd172 && b1[7:4] == 4'h1)
                  || (b0 == 8'd192 && b1 == 8'd168)
                  || (b0 == 8'd198 && b1[7:1] == 7'd9)
                  || (b0 == 8'd169 && b1 == 8'd254)
                  || (b0 == 8'd100 && b1[7:6] == 2'b01);
        v6_private = (i_peer_addr_high[63:57] == 7'h7E)
                  || (i_peer_addr_high == 64'hFE80_0000_0000_0000);
        addr_public = i_peer_is_ipv4 ? !v4_private : !v6_private;
        o_pass = (i_op == fsst_pkg::OP_REGISTER)
              && (i_msg_kind != fsst_pkg::KIND_OTHER)
              && addr_public;
    end
endmodule

[src/fsst_ram.sv]
// ----------------------------------------------------------------------------
// fsst_ram
// Simple dual port table memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module fsst_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 417,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[src/fsst_scan.sv]
// ----------------------------------------------------------------------------
// fsst_scan
// Sequencer: linear search over filled entries, ring insert, result register.
// ----------------------------------------------------------------------------
module fsst_scan #(
    parameter int TABLE_DEPTH = 256,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fsst_in_if.sink          i_item,
    fsst_out_if.source       o_result,
    input  logic             i_pass,
    output logic             o_rd_en,
    output logic [AW-1:0]    o_rd_addr,
    input  fsst_pkg::t_entry i_rd_data,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output fsst_pkg::t_entry o_wr_data
);
    fsst_pkg::t_state  r_state;
    fsst_pkg::t_state  n_state;
    logic [CW-1:0]     r_idx;
    logic              r_pend;
    logic [CW-1:0]     r_fill;
    logic [AW-1:0]     r_slot;
    logic              r_pass;
    fsst_pkg::t_entry  r_key;
    fsst_pkg::t_result r_hold;
    fsst_pkg::t_result r_out;
    logic              r_out_valid;

    logic accept;
    logic hit;
    logic more;
    logic issue;
    logic scan_end;
    logic ins;
    logic out_free;
    logic load_out;

    always_comb begin
        hit      = r_pend && (i_rd_data.hash == r_key.hash);
        more     = (r_idx != r_fill);
        issue    = (r_state == fsst_pkg::ST_SCAN) && more && !hit;
        scan_end = (r_state == fsst_pkg::ST_SCAN) && (hit || !more);
        ins      = scan_end && !hit && r_pass;
        out_free = !r_out_valid || o_result.ready;
        load_out = (r_state == fsst_pkg::ST_DONE) && out_free;
        accept   = i_item.valid && i_item.ready;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsst_pkg::ST_IDLE: begin
                if (accept) n_state = fsst_pkg::ST_SCAN;
            end
            fsst_pkg::ST_SCAN: begin
                if (scan_end) n_state = fsst_pkg::ST_DONE;
            end
            fsst_pkg::ST_DONE: begin
                if (out_free) n_state = fsst_pkg::ST_IDLE;
            end
            default: n_state = fsst_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_item.ready = (r_state == fsst_pkg::ST_IDLE);
        o_rd_en      = issue;
        o_rd_addr    = r_idx[AW-1:0];
        o_wr_en      = ins;
        o_wr_addr    = r_slot;
        o_wr_data    = r_key;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsst_pkg::ST_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_fill      <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else begin
                r_pend <= issue;
                if (issue) r_idx <= r_idx + CW'(1);
            end
            if (ins) begin
                r_slot <= (r_slot == AW'(TABLE_DEPTH - 1)) ? '0 : r_slot + AW'(1);
                if (r_fill != CW'(TABLE_DEPTH)) r_fill <= r_fill + CW'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pass          <= i_pass;
            r_key.hash      <= {i_item.hash_word3, i_item.hash_word2,
                                i_item.hash_word1, i_item.hash_word0};
            r_key.addr_high <= i_item.peer_is_ipv4 ? 64'd0 : i_item.peer_addr_high;
            r_key.addr_low  <= i_item.peer_is_ipv4 ? {32'd0, i_item.peer_addr_low[31:0]}
                                                   : i_item.peer_addr_low;
            r_key.ipv4      <= i_item.peer_is_ipv4;
            r_key.stamp     <= i_item.now_seconds;
        end
        if (scan_end) begin
            r_hold.accepted  <= r_pass;
            r_hold.inserted  <= ins;
            r_hold.found     <= hit;
            r_hold.addr_high <= hit ? i_rd_data.addr_high : 64'd0;
            r_hold.addr_low  <= hit ? i_rd_data.addr_low : 64'd0;
            r_hold.ipv4      <= hit && i_rd_data.ipv4;
            r_hold.stamp     <= hit ? i_rd_data.stamp : 32'd0;
        end
        if (load_out) begin
            r_out <= r_hold;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.accepted        = r_out.accepted;
    assign o_result.inserted        = r_out.inserted;
    assign o_result.found           = r_out.found;
    assign o_result.src_addr_high   = r_out.addr_high;
    assign o_result.src_addr_low    = r_out.addr_low;
    assign o_result.src_is_ipv4     = r_out.ipv4;
    assign o_result.first_seen_time = r_out.stamp;
endmodule

[src/first_seen_source_table.sv]
// ----------------------------------------------------------------------------
// first_seen_source_table
// Ring of the last TABLE_DEPTH distinct object hashes with first source
// address and arrival time; register and query items.
// ----------------------------------------------------------------------------
//  channel    | dir | handshake     | payload
//  i_item     | in  | valid / ready | op, hash_word0..3, peer addr, kind, time
//  o_result   | out | valid / ready | accepted, inserted, found, source, time
//
//  The search reads one filled entry per cycle on the memory read port, up to
//  TABLE_DEPTH entries. A hit ends the search early.
//  A new, accepted item is written in the last search cycle.
//  Reset clears the fill count and ring slot but not the memory; no clearing pass.
//  The next item is accepted while a result waits in the output register.
// ----------------------------------------------------------------------------
module first_seen_source_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fsst_in_if.sink     i_item,
    fsst_out_if.source  o_result
);
    localparam int AW = $clog2(TABLE_DEPTH);

    logic             pass;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    fsst_pkg::t_entry rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    fsst_pkg::t_entry wr_data;

    fsst_filter u_filter (
        .i_op             (i_item.op),
        .i_msg_kind       (i_item.msg_kind),
        .i_peer_addr_high (i_item.peer_addr_high),
        .i_peer_addr_low  (i_item.peer_addr_low),
        .i_peer_is_ipv4   (i_item.peer_is_ipv4),
        .o_pass           (pass)
    );

    fsst_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH ($bits(fsst_pkg::t_entry))
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fsst_scan #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_result  (o_result),
        .i_pass    (pass),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );
endmodule

[src/fsst_chk.sv]
// ----------------------------------------------------------------------------
// fsst_chk
// Port level checks of the first seen source table.
// ----------------------------------------------------------------------------
module fsst_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_accepted,
    input logic        i_inserted,
    input logic        i_found,
    input logic [63:0] i_src_addr_high,
    input logic [63:0] i_src_addr_low,
    input logic        i_src_is_ipv4,
    input logic [31:0] i_first_seen_time
);
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second item taken while one is searching");

    a_insert_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_inserted) |-> (i_accepted && !i_found))
        else $error("insert without acceptance or on a hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |->
            (i_src_addr_high == 64'd0 && i_src_addr_low == 64'd0 &&
             !i_src_is_ipv4 && i_first_seen_time == 32'd0))
        else $error("miss reports stored fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_found) && $stable(i_first_seen_time)))
        else $error("stalled result changed");
endmodule

bind first_seen_source_table fsst_chk u_fsst_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_item.valid),
    .i_in_ready        (i_item.ready),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_accepted        (o_result.accepted),
    .i_inserted        (o_result.inserted),
    .i_found           (o_result.found),
    .i_src_addr_high   (o_result.src_addr_high),
    .i_src_addr_low    (o_result.src_addr_low),
    .i_src_is_ipv4     (o_result.src_is_ipv4),
    .i_first_seen_time (o_result.first_seen_time)
);

[dv/fsst_checker.sv]
// ----------------------------------------------------------------------------
// fsst_checker
// Watches the item and result channels of the first seen source table, keeps
// its own copy of the hash ring and compares every result with the expected
// one, field by field, in order of acceptance.
// ----------------------------------------------------------------------------
module fsst_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    fsst_in_if   i_item,
    fsst_out_if  i_result,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int RING_DEPTH = 256;

    fsst_pkg::t_entry  ring [RING_DEPTH];
    logic              ring_valid [RING_DEPTH];
    logic [7:0]        last_slot;
    fsst_pkg::t_result expected_results[$];
    int                fails = 0;
    int                pending_count = 0;

    assign o_fail_count = fails;
    assign o_pending = pending_count;

    function automatic logic is_public_source(logic [63:0] hi, logic [63:0] lo, logic v4);
        logic [7:0] b0;
        logic [7:0] b1;
        b0 = lo[31:24];
        b1 = lo[23:16];
        if (v4) begin
            if (b0 == 8'd10) return 1'b0;
            if (b0 == 8'd172 && b1[7:4] == 4'h1) return 1'b0;
            if (b0 == 8'd192 && b1 == 8'd168) return 1'b0;
            if (b0 == 8'd198 && b1[7:1] == 7'b0001001) return 1'b0;
            if (b0 == 8'd169 && b1 == 8'd254) return 1'b0;
            if (b0 == 8'd100 && b1[7:6] == 2'b01) return 1'b0;
            return 1'b1;
        end
        if (hi[63:57] == 7'b1111110) return 1'b0;
        if (hi == 64'hFE80_0000_0000_0000) return 1'b0;
        return 1'b1;
    endfunction

    // Search first, then record a first sighting of a public, supported register item.
    function automatic fsst_pkg::t_result lookup_and_record(
        logic op, logic [255:0] hash, logic [63:0] hi_in, logic [63:0] lo_in,
        logic v4, logic [1:0] kind, logic [31:0] stamp
    );
        fsst_pkg::t_result r;
        int          hit;
        logic [63:0] hi;
        logic [63:0] lo;
        r = '0;
        hit = -1;
        hi = v4 ? 64'd0 : hi_in;
        lo = v4 ? {32'd0, lo_in[31:0]} : lo_in;
        for (int i = 0; i < RING_DEPTH; i++) begin
            if (hit < 0 && ring_valid[i] && ring[i].hash == hash) hit = i;
        end
        if (hit >= 0) begin
            r.found = 1'b1;
            r.addr_high = ring[hit].addr_high;
            r.addr_low = ring[hit].addr_low;
            r.ipv4 = ring[hit].ipv4;
            r.stamp = ring[hit].stamp;
        end
        if (op == fsst_pkg::OP_REGISTER && kind != fsst_pkg::KIND_OTHER
            && is_public_source(hi, lo, v4)) begin
            r.accepted = 1'b1;
            if (hit < 0) begin
                last_slot = last_slot + 8'd1;
                ring[last_slot].hash = hash;
                ring[last_slot].addr_high = hi;
                ring[last_slot].addr_low = lo;
                ring[last_slot].ipv4 = v4;
                ring[last_slot].stamp = stamp;
                ring_valid[last_slot] = 1'b1;
                r.inserted = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        fsst_pkg::t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < RING_DEPTH; i++) ring_valid[i] = 1'b0;
            last_slot = 8'hFF;
            expected_results.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected", $time);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", want.accepted, i_result.accepted);
                    check_field("inserted", want.inserted, i_result.inserted);
                    check_field("found", want.found, i_result.found);
                    check_field("src_addr_high", want.addr_high, i_result.src_addr_high);
                    check_field("src_addr_low", want.addr_low, i_result.src_addr_low);
                    check_field("src_is_ipv4", want.ipv4, i_result.src_is_ipv4);
                    check_field("first_seen_time", want.stamp, i_result.first_seen_time);
                end
            end
            if (i_item.valid && i_item.ready) begin
                expected_results.push_back(lookup_and_record(
                    i_item.op,
                    {i_item.hash_word3, i_item.hash_word2, i_item.hash_word1,
                     i_item.hash_word0},
                    i_item.peer_addr_high, i_item.peer_addr_low, i_item.peer_is_ipv4,
                    i_item.msg_kind, i_item.now_seconds));
            end
        end
        pending_count = expected_results.size();
    end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives register and query items into the first seen source table: directed
// filter and hit cases, then random traffic that fills and wraps the ring and
// revisits old hashes, with random idling on both channels and one long
// result stall. Checking is done by fsst_checker.
// ----------------------------------------------------------------------------
module tb_top;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   quiet = 1'b0;
    logic [255:0] seen_hashes[$];

    fsst_in_if  item_ch ();
    fsst_out_if result_ch ();

    first_seen_source_table u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    fsst_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #16000000;
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic offer_item(
        logic op, logic [255:0] hash, logic [63:0] ahi, logic [63:0] alo,
        logic v4, logic [1:0] kind, logic [31:0] stamp
    );
        item_ch.valid <= 1'b1;
        item_ch.op <= op;
        item_ch.hash_word0 <= hash[63:0];
        item_ch.hash_word1 <= hash[127:64];
        item_ch.hash_word2 <= hash[191:128];
        item_ch.hash_word3 <= hash[255:192];
        item_ch.peer_addr_high <= ahi;
        item_ch.peer_addr_low <= alo;
        item_ch.peer_is_ipv4 <= v4;
        item_ch.msg_kind <= kind;
        item_ch.now_seconds <= stamp;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    // Fresh, reused or one-bit-off hash; fresh and one-bit-off ones go to the pool.
    function automatic logic [255:0] pick_hash(int reuse_pct);
        logic [255:0] h;
        int r;
        r = $urandom_range(0, 99);
        if (seen_hashes.size() > 0 && r < reuse_pct)
            return seen_hashes[$urandom_range(0, seen_hashes.size() - 1)];
        if (seen_hashes.size() > 0 && r < reuse_pct + 5)
            h = seen_hashes[$urandom_range(0, seen_hashes.size() - 1)]
                ^ (256'd1 << $urandom_range(0, 255));
        else
            h = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        seen_hashes.push_back(h);
        return h;
    endfunction

    task automatic pick_source(int private_pct, output logic [63:0] hi,
                               output logic [63:0] lo, output logic v4);
        v4 = 1'($urandom_range(0, 1));
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        if (v4) begin
            if ($urandom_range(0, 99) < private_pct) begin
                case ($urandom_range(0, 5))
                    0: lo[31:24] = 8'd10;
                    1: lo[31:16] = {8'd172, 4'h1, lo[19:16]};
                    2: lo[31:16] = {8'd192, 8'd168};
                    3: lo[31:16] = {8'd198, 7'b0001001, lo[16]};
                    4: lo[31:16] = {8'd169, 8'd254};
                    default: lo[31:16] = {8'd100, 2'b01, lo[21:16]};
                endcase
            end else if ($urandom_range(0, 3) == 0) begin
                // just outside each private range
                case ($urandom_range(0, 5))
                    0: lo[31:24] = $urandom_range(0, 1) ? 8'd11 : 8'd9;
                    1: lo[31:16] = {8'd172, $urandom_range(0, 1) ? 8'd32 : 8'd15};
                    2: lo[31:16] = {8'd192, 8'd169};
                    3: lo[31:16] = {8'd198, 8'd20};
                    4: lo[31:16] = {8'd169, 8'd253};
                    default: lo[31:16] = {8'd100, 8'd128};
                endcase
            end
        end else begin
            if ($urandom_range(0, 99) < private_pct) begin
                if ($urandom_range(0, 1)) hi[63:57] = 7'b1111110;
                else hi = 64'hFE80_0000_0000_0000;
            end else if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: hi = 64'hFE80_0000_0000_0001;
                    1: hi = 64'hFEC0_0000_0000_0000;
                    2: hi[63:57] = 7'b1111101;
                    default: hi = 64'd0;
                endcase
            end
        end
    endtask

    initial begin : result_drain
        int taken;
        int run_len;
        bit held;
        taken = 0;
        held = 1'b0;
        result_ch.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!held && taken >= 100) begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (700) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
                run_len = quiet ? 1 : $urandom_range(1, 20);
                repeat (run_len) begin
                    @(posedge i_clk);
                    if (result_ch.valid && result_ch.ready) taken++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [255:0] hash_b;
        logic [255:0] hash_c;
        logic [255:0] hash;
        logic [63:0]  ahi;
        logic [63:0]  alo;
        logic         v4;
        logic         op;
        logic [fsst_pkg::KIND_W-1:0] kind;
        bit           early;
        int           n;

        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.op = fsst_pkg::OP_REGISTER;
        item_ch.hash_word0 = '0;
        item_ch.hash_word1 = '0;
        item_ch.hash_word2 = '0;
        item_ch.hash_word3 = '0;
        item_ch.peer_addr_high = '0;
        item_ch.peer_addr_low = '0;
        item_ch.peer_is_ipv4 = 1'b0;
        item_ch.msg_kind = fsst_pkg::KIND_UNKNOWN;
        item_ch.now_seconds = '0;
        hash_b = {4{64'h5A5A_0F0F_C3C3_0001}};
        hash_c = {64'h0123_4567_89AB_CDEF, 64'd0, 64'hFFFF_0000_FFFF_0000, 64'd7};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, then first sightings at the field extremes
        offer_item(fsst_pkg::OP_QUERY, '0, '0, '0, 1'b0, fsst_pkg::KIND_UNKNOWN, '0);
        offer_item(fsst_pkg::OP_QUERY, '1, '1, '1, 1'b1, fsst_pkg::KIND_OTHER, '1);
        offer_item(fsst_pkg::OP_REGISTER, '0, '1, 64'hFFFF_FFFF_0808_0808, 1'b1,
                   fsst_pkg::KIND_UNKNOWN, '0);
        offer_item(fsst_pkg::OP_REGISTER, '1, '1, '1, 1'b0, fsst_pkg::KIND_TX, '1);
        offer_item(fsst_pkg::OP_QUERY, '0, '0, '0, 1'b0, fsst_pkg::KIND_BLOCK, 32'd5);
        offer_item(fsst_pkg::OP_QUERY, '1, '0, '0, 1'b1, fsst_pkg::KIND_UNKNOWN, 32'd6);
        // already present: accepted, not written again; an unsupported kind is not accepted
        offer_item(fsst_pkg::OP_REGISTER, '0, '0, 64'h0101_0101, 1'b1,
                   fsst_pkg::KIND_BLOCK, 32'd123);
        offer_item(fsst_pkg::OP_REGISTER, hash_c, '0, 64'h0101_0101, 1'b1,
                   fsst_pkg::KIND_OTHER, 32'd9);
        // private sources are dropped, a hit still reports its source; then hash_b is registered from a public source
        offer_item(fsst_pkg::OP_REGISTER, '0, '0, 64'h0A01_0203, 1'b1,
                   fsst_pkg::KIND_TX, 32'd1);
        offer_item(fsst_pkg::OP_REGISTER, hash_b, '0, 64'hAC10_0001, 1'b1,
                   fsst_pkg::KIND_TX, 32'd2);
        offer_item(fsst_pkg::OP_REGISTER, hash_b, '0, 64'hAC1F_FFFF, 1'b1,
                   fsst_pkg::KIND_TX, 32'd3);
        offer_item(fsst_pkg::OP_REGISTER, hash_b, '0, 64'hC0A8_0101, 1'b1,
                   fsst_pkg::KIND_TX, 32'd4);
        offer_item(fsst_pkg::OP_REGISTER, hash_b, '0, 64'hC612_0001, 1'b1,
                   fsst_pkg::KIND_BLOCK, 32'd5);
        offer_item(fsst_pkg::OP_REGISTER, hash_b, '0, 64'hC613_FF01, 1'b1,
                   fsst_pkg::KIND_BLOCK, 32'd6);
        offer_item(fsst_pkg::OP_REGISTER, hash_b, '0, 64'hA9FE_0101, 1'b1,
                   fsst_pkg::KIND_UNKNOWN, 32'd7);
        offer_item(fsst_pkg::OP_REGISTER, hash_b, '0, 64'h6440_0001, 1'b1,
                   fsst_pkg::KIND_UNKNOWN, 32'd8);
        offer_item(fsst_pkg::OP_REGISTER, hash_b, '0, 64'h647F_FFFF, 1'b1,
                   fsst_pkg::KIND_TX, 32'd9);
        offer_item(fsst_pkg::OP_REGISTER, hash_b, 64'hFC00_0000_0000_0000, '1, 1'b0,
                   fsst_pkg::KIND_TX, 32'd10);
        offer_item(fsst_pkg::OP_REGISTER, hash_b, 64'hFD12_3456_789A_BCDE, '1, 1'b0,
                   fsst_pkg::KIND_TX, 32'd11);
        offer_item(fsst_pkg::OP_REGISTER, hash_b, 64'hFE80_0000_0000_0000, 64'd1, 1'b0,
                   fsst_pkg::KIND_TX, 32'd12);
        offer_item(fsst_pkg::OP_QUERY, hash_b, '0, '0, 1'b0, fsst_pkg::KIND_UNKNOWN, 32'd13);
        offer_item(fsst_pkg::OP_REGISTER, hash_b, '0, 64'hAC20_0001, 1'b1,
                   fsst_pkg::KIND_TX, 32'hDEAD_BEEF);
        offer_item(fsst_pkg::OP_QUERY, hash_b, '0, '0, 1'b1, fsst_pkg::KIND_OTHER, 32'd14);
        offer_item(fsst_pkg::OP_QUERY, hash_c, '0, '0, 1'b0, fsst_pkg::KIND_TX, 32'd15);
        seen_hashes.push_back('0);
        seen_hashes.push_back('1);
        seen_hashes.push_back(hash_b);
        seen_hashes.push_back(hash_c);

        // early part fills and wraps the ring, later part revisits old hashes
        for (n = 0; n < 460; n++) begin
            early = n < 300;
            quiet = n >= 400;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                item_ch.valid <= 1'b0;
                item_ch.op <= 1'($urandom_range(0, 1));
                item_ch.hash_word0 <= {$urandom, $urandom};
                item_ch.peer_addr_low <= {$urandom, $urandom};
                item_ch.msg_kind <= 2'($urandom_range(0, 3));
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            op = ($urandom_range(0, 99) < (early ? 5 : 25)) ? fsst_pkg::OP_QUERY
                                                           : fsst_pkg::OP_REGISTER;
            if ($urandom_range(0, 99) < (early ? 4 : 12)) kind = fsst_pkg::KIND_OTHER;
            else kind = fsst_pkg::KIND_W'($urandom_range(0, 2));
            hash = pick_hash(early ? 8 : 45);
            pick_source(early ? 6 : 25, ahi, alo, v4);
            offer_item(op, hash, ahi, alo, v4, kind, $urandom);
        end
        item_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
